FILE: rtl/tlw_pkg.sv
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared types, constants and the column advance function of the text line
// wrapper.
// ----------------------------------------------------------------------------
package tlw_pkg;

    // Sizes
    localparam int HOLD_DEPTH = 62;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int HCNT_W     = $clog2(HOLD_DEPTH + 1);
    localparam int TAB_STOP   = 8;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 10;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_SPACE = 2'd2;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 10'd80;

    // Character codes
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef logic [COL_W-1:0] t_col;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_NL,
        S_HELD_RD,
        S_HELD_PUT,
        S_MID_NL,
        S_CHAR
    } t_state;

    // What one item sends out, in order: newline, held bytes, newline, byte
    typedef struct packed {
        logic pre_nl;
        logic flush;
        logic mid_nl;
        logic emit_c;
    } t_plan;

    typedef struct packed {
        logic accept;
        logic put_nl;
        logic rd_held;
        logic put_held;
        logic put_char;
    } t_cmd;

    typedef struct packed {
        t_plan plan_in;
        t_plan plan;
        logic  out_free;
        logic  held_can_put;
        logic  held_last;
    } t_status;

    // Column after a byte is shown at column col.
    function automatic t_col adv(input t_col col, input logic [7:0] ch,
                                 input logic cnt_bytes);
        t_col res;
        if (cnt_bytes) begin
            res = col + t_col'(1);
        end else if (ch == CH_TAB) begin
            res = t_col'((int'(col) / TAB_STOP + 1) * TAB_STOP);
        end else if (ch == CH_BS) begin
            res = (col != '0) ? col - t_col'(1) : '0;
        end else if (ch == CH_CR) begin
            res = '0;
        end else begin
            res = col + t_col'(1);
        end
        return res;
    endfunction

endpackage

FILE: rtl/tlw_ram.sv
// ----------------------------------------------------------------------------
// tlw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tlw_datapath.sv
// ----------------------------------------------------------------------------
// tlw_datapath
// Configuration registers, column and space tracking, hold memory and the
// output register of the text line wrapper.
// ----------------------------------------------------------------------------
module tlw_datapath
    import tlw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_data,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_eof,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic                 o_out_ovf
);

    // Configuration
    logic [WIDTH_W-1:0] r_line_width;
    logic               r_count_bytes;
    logic               r_break_space;

    // Stream state
    t_col              r_column, n_column;
    logic              r_space_seen, n_space_seen;
    logic [HCNT_W-1:0] r_held_count, n_held_count;

    // Per-item registers
    logic [7:0]        r_c;
    t_plan             r_plan;
    logic              r_ovf;
    logic              r_recount;
    logic              r_skip;
    logic [HCNT_W-1:0] r_run_count;
    logic [HCNT_W-1:0] r_rd_idx;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_ovf;

    // Decision signals for the incoming byte
    t_col  w_next;
    logic  w_is_nl, w_brk, w_sb, w_pb, w_spc, w_hold_ok, w_full, w_keep;
    logic  w_ovf;
    t_plan w_plan;

    logic [7:0] w_rdata;
    logic       w_out_free, w_drop, w_load;
    logic [7:0] w_load_byte;
    logic       w_load_last;

    // Hold memory
    tlw_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && w_keep),
        .i_waddr (r_held_count[HOLD_AW-1:0]),
        .i_wdata (i_in_byte),
        .i_re    (i_cmd.rd_held),
        .i_raddr (r_rd_idx[HOLD_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Classify the incoming byte against the current line.
    always_comb begin
        w_is_nl   = (i_in_byte == CH_NL);
        w_next    = adv(r_column, i_in_byte, r_count_bytes);
        w_brk     = !w_is_nl && (w_next > t_col'(r_line_width)) && (r_column != '0);
        w_sb      = w_brk && r_break_space && r_space_seen;
        w_pb      = w_brk && !w_sb;
        w_spc     = (i_in_byte == CH_SP) || (i_in_byte == CH_VT) || (i_in_byte == CH_FF);
        w_hold_ok = !w_is_nl && !w_brk && !(w_spc && r_break_space)
                    && r_break_space && r_space_seen;
        w_full    = (r_held_count == HCNT_W'(HOLD_DEPTH));
        w_keep    = w_hold_ok && !w_full && !i_in_eof;
        w_ovf     = w_hold_ok && w_full;

        w_plan.pre_nl = w_sb;
        w_plan.flush  = !w_keep && (r_held_count != '0);
        w_plan.mid_nl = w_pb;
        w_plan.emit_c = !w_keep && !(w_sb && (r_held_count == '0) && (i_in_byte == CH_SP));
    end

    // Output register loading; a space right after a space break is dropped.
    always_comb begin
        w_out_free  = !r_out_valid || i_out_ready;
        w_drop      = r_skip && (w_rdata == CH_SP);
        w_load      = i_cmd.put_nl || i_cmd.put_char || (i_cmd.put_held && !w_drop);
        w_load_byte = CH_NL;
        w_load_last = !r_plan.emit_c;
        if (i_cmd.put_char) begin
            w_load_byte = r_c;
            w_load_last = 1'b1;
        end else if (i_cmd.put_held) begin
            w_load_byte = w_rdata;
            w_load_last = 1'b0;
        end
    end

    // Next stream state.
    always_comb begin
        n_column     = r_column;
        n_space_seen = r_space_seen;
        n_held_count = r_held_count;
        if (i_cmd.accept) begin
            n_held_count = w_keep ? r_held_count + HCNT_W'(1) : '0;
            if (i_in_eof || w_is_nl) begin
                n_column = '0;
            end else if (w_sb) begin
                n_column = '0;
            end else if (w_pb) begin
                n_column = adv('0, i_in_byte, r_count_bytes);
            end else begin
                n_column = w_next;
            end
            if (i_in_eof || w_is_nl || w_brk || w_ovf) begin
                n_space_seen = 1'b0;
            end else if (w_spc && r_break_space) begin
                n_space_seen = 1'b1;
            end
        end else if (r_recount && w_load && !i_cmd.put_nl) begin
            // Re-count the bytes that move to the new line.
            n_column = adv(r_column, w_load_byte, r_count_bytes);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= LINE_WIDTH_RST;
            r_count_bytes <= 1'b0;
            r_break_space <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data;
                CFG_COUNT_BYTES: r_count_bytes <= i_cfg_data[0];
                CFG_BREAK_SPACE: r_break_space <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stream state and per-item control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_space_seen <= 1'b0;
            r_held_count <= '0;
            r_plan       <= '0;
            r_ovf        <= 1'b0;
            r_recount    <= 1'b0;
            r_skip       <= 1'b0;
            r_run_count  <= '0;
            r_rd_idx     <= '0;
        end else begin
            r_column     <= n_column;
            r_space_seen <= n_space_seen;
            r_held_count <= n_held_count;
            if (i_cmd.accept) begin
                r_plan      <= w_plan;
                r_ovf       <= w_ovf;
                r_recount   <= w_sb && !i_in_eof;
                r_skip      <= w_sb && (r_held_count != '0);
                r_run_count <= r_held_count;
                r_rd_idx    <= '0;
            end else if (i_cmd.put_held) begin
                r_skip   <= 1'b0;
                r_rd_idx <= r_rd_idx + HCNT_W'(1);
            end
        end
    end

    // Byte of the item being worked on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c <= i_in_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_load_byte;
            r_out_last <= w_load_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_status.plan_in      = w_plan;
    assign o_status.plan         = r_plan;
    assign o_status.out_free     = w_out_free;
    assign o_status.held_can_put = w_out_free || w_drop;
    assign o_status.held_last    = ((r_rd_idx + HCNT_W'(1)) == r_run_count);

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

FILE: rtl/tlw_ctrl.sv
// ----------------------------------------------------------------------------
// tlw_ctrl
// Sequencer of the text line wrapper: takes an item, then walks through the
// newline, held bytes and current byte that the item sends out.
// ----------------------------------------------------------------------------
module tlw_ctrl
    import tlw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.plan_in.pre_nl) begin
                        n_state = S_PRE_NL;
                    end else if (i_status.plan_in.flush) begin
                        n_state = S_HELD_RD;
                    end else if (i_status.plan_in.mid_nl) begin
                        n_state = S_MID_NL;
                    end else if (i_status.plan_in.emit_c) begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_PRE_NL: begin
                if (i_status.out_free) begin
                    o_cmd.put_nl = 1'b1;
                    if (i_status.plan.flush) begin
                        n_state = S_HELD_RD;
                    end else if (i_status.plan.emit_c) begin
                        n_state = S_CHAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HELD_RD: begin
                o_cmd.rd_held = 1'b1;
                n_state       = S_HELD_PUT;
            end
            S_HELD_PUT: begin
                if (i_status.held_can_put) begin
                    o_cmd.put_held = 1'b1;
                    if (!i_status.held_last) begin
                        n_state = S_HELD_RD;
                    end else if (i_status.plan.mid_nl) begin
                        n_state = S_MID_NL;
                    end else if (i_status.plan.emit_c) begin
                        n_state = S_CHAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MID_NL: begin
                if (i_status.out_free) begin
                    o_cmd.put_nl = 1'b1;
                    n_state      = S_CHAR;
                end
            end
            S_CHAR: begin
                if (i_status.out_free) begin
                    o_cmd.put_char = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/text_line_wrapper_core.sv
// ----------------------------------------------------------------------------
// text_line_wrapper_core
// Inserts newlines into a text byte stream so that no line exceeds the set
// width, optionally breaking after the last space of the line.
// ----------------------------------------------------------------------------
// Flow: each byte that goes out is loaded into the output register; a held byte
// is first read from the hold memory, then loaded. A byte that is only held
// goes to the hold memory; a new byte is taken only once the sequencer is back
// in idle, after all output of the last byte is loaded. Output stalls hold it.
// Reset: synchronous, active low; clears the sequencer, column, space flag,
// hold count and output register, and loads the register reset values.
module text_line_wrapper_core
    import tlw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
    input  logic                 s_axis_tlast,  // end_of_file
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
    output logic                 m_axis_tlast,  // last_of_run
    output logic                 m_axis_tuser   // [0] hold_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    tlw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tlw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (s_axis_tdata),
        .i_in_eof    (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

FILE: rtl/tlw_checker.sv
// ----------------------------------------------------------------------------
// tlw_checker
// Port-level checks of the text line wrapper, bound to the top level.
// ----------------------------------------------------------------------------
module tlw_checker
    import tlw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // A waiting input byte keeps its contents until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("waiting input changed");

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The overflow flag is the same on every result of one run.
    a_ovf_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser)))
        else $error("overflow flag changed within a run");

    // No new byte is taken while a run is still being sent out.
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a run");

endmodule

bind text_line_wrapper_core tlw_checker u_tlw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
